/* rtl/dbkf_pkg.sv */
// Shared types and constants of the degree-bounded Kruskal edge filter.
`timescale 1ns / 1ps

package dbkf_pkg;

  localparam int unsigned OP_W     = 1;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned NCOUNT_W = 11;
  localparam int unsigned DEG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic [DEG_W-1:0]    DEGREE_CAP_RST = 4'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_CAP = 1'b1;

  localparam logic [OP_W-1:0] OP_OFFER   = 1'b0;
  localparam logic [OP_W-1:0] OP_RESTART = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT   = 3'd0,
    ST_SAME     = 3'd1,
    ST_DEGREE   = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_BADID    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_S,
    S_FIND_E,
    S_UPDATE_A,
    S_UPDATE_B,
    S_REPLY
  } state_e;

endpackage

/* rtl/dbkf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dbkf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/degree_bounded_kruskal_filter.sv */
// Top level of the degree-bounded Kruskal edge filter.
`timescale 1ns / 1ps

// Degree-bounded Kruskal edge filter. Offer candidate edges (op 0) in the
// order you want them considered, normally ascending weight; each input beat
// yields exactly one output beat with a status, the running count of accepted
// edges and a tree-complete flag. An edge is taken when its endpoints sit in
// different components and both endpoint degrees are below the degree cap; the
// start root is then linked under the end root. Op 1 restarts the forest.
// The forest lives in two RAMs of MAX_NODES entries (parent and degree), each
// with a registered read. Steps per item: an edge refused as tree complete or
// bad id goes from idle straight to the reply step; an edge that is walked
// follows the start node and then the end node up to its root through the
// parent RAM, one hop per cycle, and an accepted edge then passes through
// the write states S_UPDATE_A and S_UPDATE_B. A restart sweeps both RAMs one
// entry a cycle. After reset the same sweep runs with in_ready_o low;
// configuration writes are taken at all times (cfg_ready_o is tied high) but
// should only be issued while idle.
// A finished result waits in the output register while the next item is
// taken and walked; the reply step holds while that register is still full.
module degree_bounded_kruskal_filter #(
  parameter int unsigned MAX_NODES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbkf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dbkf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dbkf_pkg::OP_W-1:0]           op_i,
  input  logic [dbkf_pkg::NODE_W-1:0]         start_node_i,
  input  logic [dbkf_pkg::NODE_W-1:0]         end_node_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dbkf_pkg::STATUS_W-1:0]       status_o,
  output logic [dbkf_pkg::COUNT_W-1:0]        accepted_count_o,
  output logic                                tree_done_o
);

  // Node index width, and a compare width that holds both the 11-bit node
  // count register and MAX_NODES itself.
  localparam int unsigned AW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = (AW + 1 > dbkf_pkg::NCOUNT_W) ? AW + 1 : dbkf_pkg::NCOUNT_W;
  localparam int unsigned EXW = (AW > dbkf_pkg::COUNT_W) ? AW : dbkf_pkg::COUNT_W;
  localparam logic [CW-1:0] MaxNodesC = CW'(MAX_NODES);
  localparam logic [AW-1:0] LastAddrC = AW'(MAX_NODES - 1);

  // Configuration registers
  logic [dbkf_pkg::NCOUNT_W-1:0] node_count_q;
  logic [dbkf_pkg::DEG_W-1:0]    degree_cap_q;

  // Control state
  dbkf_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_reply_q, clr_reply_d;
  logic [AW-1:0]    tree_edges_q, tree_edges_d;
  logic             out_valid_q, out_valid_d;

  // Item working registers
  logic [dbkf_pkg::OP_W-1:0]  op_q, op_d;
  logic [AW-1:0]              s_q, s_d;
  logic [AW-1:0]              e_q, e_d;
  logic [AW-1:0]              cur_q, cur_d;
  logic                       first_q, first_d;
  logic [AW-1:0]              rs_q, rs_d;
  logic [AW-1:0]              re_q, re_d;
  logic [dbkf_pkg::DEG_W-1:0] deg_s_q, deg_s_d;
  logic [dbkf_pkg::DEG_W-1:0] deg_e_q, deg_e_d;
  dbkf_pkg::status_e          status_q, status_d;

  // Output payload registers
  dbkf_pkg::status_e          out_status_q, out_status_d;
  logic [dbkf_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  logic                       out_done_q, out_done_d;

  // RAM ports
  logic                       par_we, deg_we, mem_re;
  logic [AW-1:0]              par_waddr, deg_waddr, mem_raddr;
  logic [AW-1:0]              par_wdata, par_rdata;
  logic [dbkf_pkg::DEG_W-1:0] deg_wdata, deg_rdata;

  // Derived limits
  logic [CW-1:0] ncount_ext, live_count, edge_limit, edges_ext;
  logic          tree_full, bad_id, in_beat, out_free;
  logic [dbkf_pkg::DEG_W-1:0] deg_e_now;
  logic [EXW-1:0] edges_wide;

  assign ncount_ext = CW'(node_count_q);
  assign live_count = (ncount_ext > MaxNodesC) ? MaxNodesC : ncount_ext;
  assign edge_limit = (live_count == '0) ? '0 : live_count - CW'(1);
  assign edges_ext  = CW'(tree_edges_q);
  assign tree_full  = (edges_ext >= edge_limit);
  assign bad_id     = (CW'(start_node_i) >= live_count) || (CW'(end_node_i) >= live_count);
  assign edges_wide = EXW'(tree_edges_q);

  assign in_ready_o  = (state_q == dbkf_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign deg_e_now   = first_q ? deg_rdata : deg_e_q;

  // Configuration writes; an index outside the list is not possible at this width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dbkf_pkg::NODE_COUNT_RST;
      degree_cap_q <= dbkf_pkg::DEGREE_CAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dbkf_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        dbkf_pkg::CFG_DEGREE_CAP: degree_cap_q <= cfg_data_i[dbkf_pkg::DEG_W-1:0];
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dbkf_pkg::S_CLEAR: begin
        if (clr_addr_q == LastAddrC) begin
          state_d = clr_reply_q ? dbkf_pkg::S_REPLY : dbkf_pkg::S_IDLE;
        end
      end
      dbkf_pkg::S_IDLE: begin
        if (in_beat) begin
          if (op_i == dbkf_pkg::OP_RESTART) begin
            state_d = dbkf_pkg::S_CLEAR;
          end else if (tree_full || bad_id) begin
            state_d = dbkf_pkg::S_REPLY;
          end else begin
            state_d = dbkf_pkg::S_FIND_S;
          end
        end
      end
      dbkf_pkg::S_FIND_S: begin
        if (par_rdata == cur_q) begin
          state_d = dbkf_pkg::S_FIND_E;
        end
      end
      dbkf_pkg::S_FIND_E: begin
        if (par_rdata == cur_q) begin
          if (rs_q == cur_q || deg_s_q >= degree_cap_q || deg_e_now >= degree_cap_q) begin
            state_d = dbkf_pkg::S_REPLY;
          end else begin
            state_d = dbkf_pkg::S_UPDATE_A;
          end
        end
      end
      dbkf_pkg::S_UPDATE_A: state_d = dbkf_pkg::S_UPDATE_B;
      dbkf_pkg::S_UPDATE_B: state_d = dbkf_pkg::S_REPLY;
      dbkf_pkg::S_REPLY: begin
        if (out_free) begin
          state_d = dbkf_pkg::S_IDLE;
        end
      end
      default: state_d = dbkf_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    clr_addr_d   = clr_addr_q;
    clr_reply_d  = clr_reply_q;
    tree_edges_d = tree_edges_q;
    op_d         = op_q;
    s_d          = s_q;
    e_d          = e_q;
    cur_d        = cur_q;
    first_d      = first_q;
    rs_d         = rs_q;
    re_d         = re_q;
    deg_s_d      = deg_s_q;
    deg_e_d      = deg_e_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_done_d   = out_done_q;
    par_we       = 1'b0;
    deg_we       = 1'b0;
    mem_re       = 1'b0;
    par_waddr    = clr_addr_q;
    deg_waddr    = clr_addr_q;
    par_wdata    = clr_addr_q;
    deg_wdata    = '0;
    mem_raddr    = cur_q;

    // drop the waiting result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      dbkf_pkg::S_CLEAR: begin
        // restore identity parents and zero degrees, one entry a cycle
        par_we     = 1'b1;
        deg_we     = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddrC) begin
          clr_addr_d = '0;
        end
      end
      dbkf_pkg::S_IDLE: begin
        if (in_beat) begin
          op_d = op_i;
          s_d  = AW'(start_node_i);
          e_d  = AW'(end_node_i);
          if (op_i == dbkf_pkg::OP_RESTART) begin
            tree_edges_d = '0;
            clr_addr_d   = '0;
            clr_reply_d  = 1'b1;
            status_d     = dbkf_pkg::ST_BADID;
          end else if (tree_full) begin
            status_d = dbkf_pkg::ST_COMPLETE;
          end else if (bad_id) begin
            status_d = dbkf_pkg::ST_BADID;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(start_node_i);
            cur_d     = AW'(start_node_i);
            first_d   = 1'b1;
          end
        end
      end
      dbkf_pkg::S_FIND_S: begin
        first_d = 1'b0;
        if (first_q) begin
          deg_s_d = deg_rdata;
        end
        mem_re = 1'b1;
        if (par_rdata == cur_q) begin
          // start root found; begin the end-node walk
          rs_d      = cur_q;
          mem_raddr = e_q;
          cur_d     = e_q;
          first_d   = 1'b1;
        end else begin
          mem_raddr = par_rdata;
          cur_d     = par_rdata;
        end
      end
      dbkf_pkg::S_FIND_E: begin
        first_d = 1'b0;
        deg_e_d = deg_e_now;
        if (par_rdata == cur_q) begin
          re_d = cur_q;
          if (rs_q == cur_q) begin
            status_d = dbkf_pkg::ST_SAME;
          end else if (deg_s_q >= degree_cap_q || deg_e_now >= degree_cap_q) begin
            status_d = dbkf_pkg::ST_DEGREE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = par_rdata;
          cur_d     = par_rdata;
        end
      end
      dbkf_pkg::S_UPDATE_A: begin
        // link start root under end root, bump start degree
        par_we    = 1'b1;
        par_waddr = rs_q;
        par_wdata = re_q;
        deg_we    = 1'b1;
        deg_waddr = s_q;
        deg_wdata = deg_s_q + dbkf_pkg::DEG_W'(1);
      end
      dbkf_pkg::S_UPDATE_B: begin
        deg_we       = 1'b1;
        deg_waddr    = e_q;
        deg_wdata    = deg_e_q + dbkf_pkg::DEG_W'(1);
        tree_edges_d = tree_edges_q + AW'(1);
        status_d     = dbkf_pkg::ST_ACCEPT;
      end
      dbkf_pkg::S_REPLY: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = edges_wide[dbkf_pkg::COUNT_W-1:0];
          out_done_d   = (op_q == dbkf_pkg::OP_OFFER) && tree_full;
          clr_reply_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dbkf_pkg::S_CLEAR;
      clr_addr_q   <= '0;
      clr_reply_q  <= 1'b0;
      tree_edges_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_reply_q  <= clr_reply_d;
      tree_edges_q <= tree_edges_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    s_q          <= s_d;
    e_q          <= e_d;
    cur_q        <= cur_d;
    first_q      <= first_d;
    rs_q         <= rs_d;
    re_q         <= re_d;
    deg_s_q      <= deg_s_d;
    deg_e_q      <= deg_e_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_done_q   <= out_done_d;
  end

  dbkf_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_NODES)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (par_rdata)
  );

  dbkf_ram #(
    .WIDTH (dbkf_pkg::DEG_W),
    .DEPTH (MAX_NODES)
  ) u_degree_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (deg_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign accepted_count_o = out_count_q;
  assign tree_done_o      = out_done_q;

endmodule

/* rtl/dbkf_checker.sv */
// Port-level checker for the degree-bounded Kruskal edge filter, bound to the top level.
`timescale 1ns / 1ps

module dbkf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [dbkf_pkg::STATUS_W-1:0]   status_o,
  input logic [dbkf_pkg::COUNT_W-1:0]    accepted_count_o,
  input logic                            tree_done_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(accepted_count_o)
      && $stable(tree_done_o))
    else $error("stalled result beat changed");

  // one item at a time: no input beat straight after an input beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item still in work");

  // a tree-complete refusal always reports the tree as done
  a_complete_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dbkf_pkg::ST_COMPLETE |-> tree_done_o)
    else $error("tree complete status without tree_done");

  // a refusal on component or degree leaves the tree unfinished
  a_refuse_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == dbkf_pkg::ST_SAME || status_o == dbkf_pkg::ST_DEGREE)
      |-> !tree_done_o)
    else $error("refused edge reported with a finished tree");

endmodule

bind degree_bounded_kruskal_filter dbkf_checker u_dbkf_checker (.*);

/* sim/tb_degree_bounded_kruskal_filter.sv */
// Self-checking testbench of the degree-bounded Kruskal edge filter.
`timescale 1ns / 1ps

module tb_degree_bounded_kruskal_filter;

  localparam int unsigned NODES         = 1024;
  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 40;
  // the deepest walk visits every node for both endpoints; random trees stay far shallower
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  localparam int unsigned NW = dbkf_pkg::NODE_W;
  localparam int unsigned DW = dbkf_pkg::CFG_DATA_W;

  typedef struct packed {
    dbkf_pkg::status_e            status;
    logic [dbkf_pkg::COUNT_W-1:0] count;
    logic                         done;
  } verdict_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [dbkf_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [DW-1:0]                   cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [dbkf_pkg::OP_W-1:0]       op_i = dbkf_pkg::OP_OFFER;
  logic [NW-1:0]                   start_node_i = '0;
  logic [NW-1:0]                   end_node_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b1;
  logic [dbkf_pkg::STATUS_W-1:0]   status_o;
  logic [dbkf_pkg::COUNT_W-1:0]    accepted_count_o;
  logic                            tree_done_o;

  // shadow of the forest and of the two registers
  logic [NW-1:0]                   forest_parent [NODES];
  logic [dbkf_pkg::DEG_W-1:0]      node_degree [NODES];
  int unsigned                     edges_taken;
  logic [dbkf_pkg::NCOUNT_W-1:0]   node_count_reg;
  logic [dbkf_pkg::DEG_W-1:0]      degree_cap_reg;

  verdict_t              pending_verdicts[$];
  int unsigned           path_order [NODES];
  int unsigned           items_sent = 0;
  int unsigned           mismatch_count = 0;
  longint unsigned       cycle_count = 0;
  bit                    traffic_gaps = 1'b1;
  int unsigned           ready_hold = 0;

  degree_bounded_kruskal_filter #(
    .MAX_NODES(NODES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .start_node_i     (start_node_i),
    .end_node_i       (end_node_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .accepted_count_o (accepted_count_o),
    .tree_done_o      (tree_done_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Forest predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned live_nodes();
    return (node_count_reg > NODES) ? NODES : node_count_reg;
  endfunction

  function automatic void clear_forest();
    for (int unsigned i = 0; i < NODES; i++) begin
      forest_parent[i] = NW'(i);
      node_degree[i]   = '0;
    end
    edges_taken = 0;
  endfunction

  function automatic int unsigned find_root(input int unsigned node);
    int unsigned hops;
    hops = 0;
    while (forest_parent[node] != node && hops < NODES) begin
      node = forest_parent[node];
      hops++;
    end
    return node;
  endfunction

  // Advance the shadow forest by one beat and return the result it must give.
  function automatic verdict_t predict_verdict(input logic [dbkf_pkg::OP_W-1:0] op,
                                               input logic [NW-1:0] s,
                                               input logic [NW-1:0] e);
    verdict_t    v;
    int unsigned live;
    int unsigned limit;
    int unsigned rs;
    int unsigned re;
    live  = live_nodes();
    limit = (live == 0) ? 0 : live - 1;
    if (op == dbkf_pkg::OP_RESTART) begin
      clear_forest();
      v.status = dbkf_pkg::ST_BADID;
    end else if (edges_taken >= limit) begin
      // a full tree wins over every other refusal
      v.status = dbkf_pkg::ST_COMPLETE;
    end else if (s >= live || e >= live) begin
      v.status = dbkf_pkg::ST_BADID;
    end else begin
      rs = find_root(s);
      re = find_root(e);
      if (rs == re) begin
        v.status = dbkf_pkg::ST_SAME;
      end else if (node_degree[s] >= degree_cap_reg || node_degree[e] >= degree_cap_reg) begin
        v.status = dbkf_pkg::ST_DEGREE;
      end else begin
        node_degree[s]++;
        node_degree[e]++;
        forest_parent[rs] = NW'(re);
        edges_taken++;
        v.status = dbkf_pkg::ST_ACCEPT;
      end
    end
    v.count = dbkf_pkg::COUNT_W'(edges_taken);
    v.done  = (op == dbkf_pkg::OP_OFFER) && (edges_taken >= limit);
    return v;
  endfunction

  function automatic void shuffle_path(input int unsigned n);
    int unsigned j;
    int unsigned t;
    for (int unsigned i = 0; i < n; i++) path_order[i] = i;
    for (int unsigned i = n; i > 1; i--) begin
      j = $urandom_range(0, i - 1);
      t = path_order[i - 1];
      path_order[i - 1] = path_order[j];
      path_order[j] = t;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Send one beat; valid stays high into the next call unless a gap is taken.
  task automatic send_item(input logic [dbkf_pkg::OP_W-1:0] op, input logic [NW-1:0] s,
                           input logic [NW-1:0] e);
    if (traffic_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    start_node_i <= s;
    end_node_i   <= e;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(predict_verdict(op, s, e));
    items_sent++;
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dbkf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [DW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == dbkf_pkg::CFG_NODE_COUNT) node_count_reg = value;
    else if (idx == dbkf_pkg::CFG_DEGREE_CAP) degree_cap_reg = value[dbkf_pkg::DEG_W-1:0];
  endtask

  // Result side stalls in bursts; hold ready high once gaps are switched off.
  always @(posedge clk_i) begin
    if (!traffic_gaps) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold  <= $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b1;
      ready_hold  <= $urandom_range(0, 12);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_beat
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual status %0d count %0d done %0d",
                 $time, status_o, accepted_count_o, tree_done_o);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (accepted_count_o !== want.count) begin
          $display("%0t: accepted_count expected %0d, actual %0d",
                   $time, want.count, accepted_count_o);
          mismatch_count++;
        end
        if (tree_done_o !== want.done) begin
          $display("%0t: tree_done expected %0d, actual %0d", $time, want.done, tree_done_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: full-width ids, self loop, cycle and a degree cap of three.
  task automatic test_reset_defaults();
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'h3FF);
    send_item(dbkf_pkg::OP_OFFER, 10'h3FF, 10'd0);
    send_item(dbkf_pkg::OP_OFFER, 10'h155, 10'h155);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'h2AA);
    send_item(dbkf_pkg::OP_OFFER, 10'h155, 10'd0);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'h3F0);
  endtask

  // Shrink the tree under live edges, then build a full four-node path.
  task automatic test_small_tree();
    write_reg(dbkf_pkg::CFG_NODE_COUNT, 11'd4);
    write_reg(dbkf_pkg::CFG_DEGREE_CAP, 11'd15);
    send_item(dbkf_pkg::OP_OFFER, 10'd1, 10'd2);
    send_item(dbkf_pkg::OP_RESTART, 10'h3FF, 10'h3FF);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'd4);
    send_item(dbkf_pkg::OP_OFFER, 10'h3FF, 10'd1);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'd1);
    send_item(dbkf_pkg::OP_OFFER, 10'd1, 10'd2);
    send_item(dbkf_pkg::OP_OFFER, 10'd2, 10'd3);
    send_item(dbkf_pkg::OP_OFFER, 10'd3, 10'd0);
  endtask

  // Node counts of zero, one and beyond the store size.
  task automatic test_node_count_extremes();
    write_reg(dbkf_pkg::CFG_NODE_COUNT, 11'd0);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'd0);
    write_reg(dbkf_pkg::CFG_NODE_COUNT, 11'd1);
    send_item(dbkf_pkg::OP_RESTART, 10'd0, 10'd0);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'd0);
    write_reg(dbkf_pkg::CFG_NODE_COUNT, 11'd2047);
    send_item(dbkf_pkg::OP_RESTART, 10'd0, 10'd0);
    send_item(dbkf_pkg::OP_OFFER, 10'h3FF, 10'h200);
  endtask

  task automatic test_degree_limits();
    write_reg(dbkf_pkg::CFG_DEGREE_CAP, 11'd0);
    send_item(dbkf_pkg::OP_OFFER, 10'd1, 10'd2);
    write_reg(dbkf_pkg::CFG_DEGREE_CAP, 11'd1);
    send_item(dbkf_pkg::OP_OFFER, 10'd1, 10'd2);
    send_item(dbkf_pkg::OP_OFFER, 10'd2, 10'd3);
    send_item(dbkf_pkg::OP_OFFER, 10'd0, 10'h3FF);
  endtask

  // Random phases: new registers, usually a restart, then mostly well-formed
  // tree building (a spanning path, random pairs, a hub) with some noise.
  task automatic test_random_forests();
    int unsigned first;
    int unsigned n;
    int unsigned phase_len;
    int unsigned path_pos;
    int unsigned a;
    int unsigned b;
    int unsigned t;
    int unsigned r;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      // calm tail: no idling on either side
      if (items_sent - first > RANDOM_ITEMS * 85 / 100) traffic_gaps = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 99);
        if (r < 60)      write_reg(dbkf_pkg::CFG_NODE_COUNT, DW'($urandom_range(2, 40)));
        else if (r < 75) write_reg(dbkf_pkg::CFG_NODE_COUNT, DW'($urandom_range(41, 200)));
        else if (r < 85) write_reg(dbkf_pkg::CFG_NODE_COUNT, 11'd1024);
        else if (r < 91) write_reg(dbkf_pkg::CFG_NODE_COUNT, DW'($urandom_range(1025, 2047)));
        else             write_reg(dbkf_pkg::CFG_NODE_COUNT, DW'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 99);
        if (r < 5)       write_reg(dbkf_pkg::CFG_DEGREE_CAP, 11'd0);
        else if (r < 15) write_reg(dbkf_pkg::CFG_DEGREE_CAP, 11'd1);
        else if (r < 65) write_reg(dbkf_pkg::CFG_DEGREE_CAP, DW'($urandom_range(2, 4)));
        else if (r < 85) write_reg(dbkf_pkg::CFG_DEGREE_CAP, 11'd15);
        else             write_reg(dbkf_pkg::CFG_DEGREE_CAP, DW'($urandom_range(5, 14)));
      end
      // skip the restart now and then so new registers meet a live tree
      if ($urandom_range(0, 4) != 0)
        send_item(dbkf_pkg::OP_RESTART, NW'($urandom), NW'($urandom));
      n = live_nodes();
      shuffle_path(n);
      path_pos  = 0;
      phase_len = $urandom_range(8, (2 * n + 10 > 80) ? 80 : 2 * n + 10);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        a = $urandom_range(0, NODES - 1);
        b = $urandom_range(0, NODES - 1);
        if (n >= 2 && r < 93) begin
          if (r < 45 && path_pos + 1 < n) begin
            a = path_order[path_pos];
            b = path_order[path_pos + 1];
            path_pos++;
            if ($urandom_range(0, 1) == 1) begin
              t = a;
              a = b;
              b = t;
            end
          end else if (r < 80) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
          end else if (r < 88) begin
            a = path_order[0];
            b = $urandom_range(0, n - 1);
          end else begin
            a = $urandom_range(0, n - 1);
            b = a;
          end
        end
        if (r >= 97) begin
          send_item(dbkf_pkg::OP_RESTART, NW'(a), NW'(b));
          path_pos = 0;
        end else begin
          send_item(dbkf_pkg::OP_OFFER, NW'(a), NW'(b));
        end
      end
    end
  endtask

  initial begin
    node_count_reg = dbkf_pkg::NODE_COUNT_RST;
    degree_cap_reg = dbkf_pkg::DEGREE_CAP_RST;
    clear_forest();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_small_tree();
    test_node_count_extremes();
    test_degree_limits();
    test_random_forests();

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* degree_bounded_kruskal_filter.f */
rtl/dbkf_pkg.sv
rtl/dbkf_ram.sv
rtl/degree_bounded_kruskal_filter.sv
rtl/dbkf_checker.sv
sim/tb_degree_bounded_kruskal_filter.sv
